@@ hdl/qpr_pkg.sv @@
// ---------------------------------------------------------------------------
// qpr_pkg
// Shared types and codes for the quaternion product / rotate unit.
// ---------------------------------------------------------------------------
package qpr_pkg;

	localparam int COMP_W = 32;
	localparam int TOL_W  = 20;
	localparam int OP_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CROSS  = 2'd0,
		OP_DOT    = 2'd1,
		OP_ROTATE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef logic signed [COMP_W-1:0] comp_t;

	// one quaternion: x, y, z, s
	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t s;
	} quat_t;

	typedef struct packed {
		logic v;
		logic clip;
	} qctl_t;

endpackage

@@ hdl/qpr_qmul.sv @@
// ---------------------------------------------------------------------------
// qpr_qmul
// Pipelined quaternion product: 16 rounded products, sums, saturation.
// Stage 1 registers operands, stage 2 the rounded products, stage 3 the
// saturated result. csign high selects + cross. conj_r high multiplies by
// the conjugate of r; the vector part of r is negated after sign extension,
// so the most negative component stays exact.
// ---------------------------------------------------------------------------
module qpr_qmul #(
	parameter int FRAC_BITS = 29
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_v,
	input  qpr_pkg::quat_t        l,
	input  qpr_pkg::quat_t        r,
	input  logic                  csign,
	input  logic                  conj_r,
	output logic                  out_v,
	output qpr_pkg::quat_t        o,
	output logic                  clip
);

	localparam int PW = 2 * qpr_pkg::COMP_W + 1;
	localparam int SW = PW - FRAC_BITS + 3;
	localparam int EW = qpr_pkg::COMP_W + 1;
	localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SMIN = SW'(-64'sd2147483648);

	logic v_s1, v_s2, v_s3;
	qpr_pkg::quat_t l_s1;
	logic signed [EW-1:0] ra_s1 [4];
	logic cs_s1, cs_s2;
	// products [i][j] = l[i]*r[j], index order x,y,z,s
	logic signed [PW-FRAC_BITS-1:0] p_s2 [4][4];
	qpr_pkg::quat_t o_s3;
	logic clip_s3;

	logic signed [qpr_pkg::COMP_W-1:0] la [4];
	assign la[0] = l_s1.x; assign la[1] = l_s1.y; assign la[2] = l_s1.z; assign la[3] = l_s1.s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		l_s1     <= l;
		ra_s1[0] <= conj_r ? -EW'(r.x) : EW'(r.x);
		ra_s1[1] <= conj_r ? -EW'(r.y) : EW'(r.y);
		ra_s1[2] <= conj_r ? -EW'(r.z) : EW'(r.z);
		ra_s1[3] <= EW'(r.s);
		cs_s1    <= csign;
		cs_s2    <= cs_s1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				p_s2[i][j] <= (PW-FRAC_BITS)'((PW'(la[i]) * PW'(ra_s1[j]) + RND) >>> FRAC_BITS);
			end
		end
	end

	logic signed [SW-1:0] cr [3], sum [4];
	logic signed [SW-1:0] sat [4];
	logic cl;

	function automatic logic signed [SW-1:0] ex(input logic signed [PW-FRAC_BITS-1:0] v);
		return SW'(v);
	endfunction

	always_comb begin
		cr[0] = ex(p_s2[1][2]) - ex(p_s2[2][1]);
		cr[1] = ex(p_s2[2][0]) - ex(p_s2[0][2]);
		cr[2] = ex(p_s2[0][1]) - ex(p_s2[1][0]);
		for (int i = 0; i < 3; i++) begin
			sum[i] = ex(p_s2[i][3]) + ex(p_s2[3][i]) + (cs_s2 ? cr[i] : -cr[i]);
		end
		sum[3] = ex(p_s2[3][3]) - ex(p_s2[0][0]) - ex(p_s2[1][1]) - ex(p_s2[2][2]);
		cl = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (sum[i] > SMAX) begin
				sat[i] = SMAX;
				cl = 1'b1;
			end else if (sum[i] < SMIN) begin
				sat[i] = SMIN;
				cl = 1'b1;
			end else begin
				sat[i] = sum[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		o_s3.x  <= sat[0][qpr_pkg::COMP_W-1:0];
		o_s3.y  <= sat[1][qpr_pkg::COMP_W-1:0];
		o_s3.z  <= sat[2][qpr_pkg::COMP_W-1:0];
		o_s3.s  <= sat[3][qpr_pkg::COMP_W-1:0];
		clip_s3 <= cl;
	end

	assign out_v = v_s3;
	assign o     = o_s3;
	assign clip  = clip_s3;

endmodule

@@ hdl/quaternion_product_rotate_unit.sv @@
// ---------------------------------------------------------------------------
// quaternion_product_rotate_unit
// Quaternion product (either cross sign) and vector rotation, Q2.29.
// ---------------------------------------------------------------------------
// Takes one request per cycle (busy is always low) and returns its result
// with done high for one cycle; the receiver cannot stall.
// Results pass two chained 3-stage quaternion multipliers plus an
// output register; product ops pass through a delay line to match. The
// norm check for rotate runs alongside the first multiplier.
module quaternion_product_rotate_unit #(
	parameter int FRAC_BITS = 29
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [qpr_pkg::OP_W-1:0]           op,
	input  logic signed [qpr_pkg::COMP_W-1:0]  a_x, a_y, a_z, a_s,
	input  logic signed [qpr_pkg::COMP_W-1:0]  b_x, b_y, b_z, b_s,
	input  logic                               tol_we,
	input  logic [qpr_pkg::TOL_W-1:0]          tol_wdata,
	output logic                               done,
	output logic signed [qpr_pkg::COMP_W-1:0]  res_x, res_y, res_z, res_s,
	output logic                               not_unit,
	output logic                               saturated
);

	localparam int PW = 2 * qpr_pkg::COMP_W + 1;
	localparam int NW = PW - FRAC_BITS + 3;
	localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [NW-1:0] ONE = NW'(1) <<< FRAC_BITS;
	localparam int D1 = 3;

	logic [qpr_pkg::TOL_W-1:0] tol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= qpr_pkg::TOL_W'(4);
		else if (tol_we) tol_q <= tol_wdata;
	end

	assign busy = 1'b0;

	qpr_pkg::quat_t qa, qv;
	assign qa = '{a_x, a_y, a_z, a_s};
	assign qv = '{b_x, b_y, b_z,
		(qpr_pkg::op_t'(op) == qpr_pkg::OP_ROTATE) ? qpr_pkg::comp_t'(0) : b_s};

	logic m1_v, m1_clip;
	qpr_pkg::quat_t m1_o;
	qpr_qmul #(.FRAC_BITS(FRAC_BITS)) u_m1 (
		.clk, .arst_n, .in_v(start), .l(qa), .r(qv),
		.csign(qpr_pkg::op_t'(op) == qpr_pkg::OP_DOT), .conj_r(1'b0),
		.out_v(m1_v), .o(m1_o), .clip(m1_clip)
	);

	// op and A ride along the first multiplier
	qpr_pkg::op_t op_d [D1];
	qpr_pkg::quat_t a_d [D1];
	always_ff @(posedge clk) begin
		op_d[0] <= qpr_pkg::op_t'(op);
		a_d[0]  <= qa;
		for (int i = 1; i < D1; i++) begin
			op_d[i] <= op_d[i-1];
			a_d[i]  <= a_d[i-1];
		end
	end

	// norm check: squares, sum, compare across the same three stages
	logic signed [PW-FRAC_BITS-1:0] sq_s1 [4];
	logic signed [NW-1:0] dev_s2;
	logic nu_s3;
	logic [NW-1:0] adev;
	always_ff @(posedge clk) begin
		sq_s1[0] <= (PW-FRAC_BITS)'((PW'(a_x) * PW'(a_x) + RND) >>> FRAC_BITS);
		sq_s1[1] <= (PW-FRAC_BITS)'((PW'(a_y) * PW'(a_y) + RND) >>> FRAC_BITS);
		sq_s1[2] <= (PW-FRAC_BITS)'((PW'(a_z) * PW'(a_z) + RND) >>> FRAC_BITS);
		sq_s1[3] <= (PW-FRAC_BITS)'((PW'(a_s) * PW'(a_s) + RND) >>> FRAC_BITS);
		dev_s2 <= NW'(sq_s1[0]) + NW'(sq_s1[1]) + NW'(sq_s1[2]) + NW'(sq_s1[3]) - ONE;
		nu_s3 <= adev > NW'(tol_q);
	end
	assign adev = dev_s2[NW-1] ? -dev_s2 : dev_s2;

	// second product takes conj(A); the multiplier negates after extension
	logic m2_v, m2_clip;
	qpr_pkg::quat_t m2_o;
	qpr_qmul #(.FRAC_BITS(FRAC_BITS)) u_m2 (
		.clk, .arst_n, .in_v(m1_v), .l(m1_o), .r(a_d[D1-1]),
		.csign(1'b0), .conj_r(1'b1),
		.out_v(m2_v), .o(m2_o), .clip(m2_clip)
	);

	// second half delay
	qpr_pkg::op_t op_e [D1];
	qpr_pkg::quat_t r1_e [D1];
	logic c1_e [D1];
	logic nu_e [D1];
	always_ff @(posedge clk) begin
		op_e[0] <= op_d[D1-1];
		r1_e[0] <= m1_o;
		c1_e[0] <= m1_clip;
		nu_e[0] <= nu_s3;
		for (int i = 1; i < D1; i++) begin
			op_e[i] <= op_e[i-1];
			r1_e[i] <= r1_e[i-1];
			c1_e[i] <= c1_e[i-1];
			nu_e[i] <= nu_e[i-1];
		end
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= m2_v;
	end

	always_ff @(posedge clk) begin
		unique case (op_e[D1-1])
			qpr_pkg::OP_CROSS, qpr_pkg::OP_DOT: begin
				{res_x, res_y, res_z, res_s} <= r1_e[D1-1];
				not_unit  <= 1'b0;
				saturated <= c1_e[D1-1];
			end
			qpr_pkg::OP_ROTATE: begin
				if (nu_e[D1-1]) begin
					{res_x, res_y, res_z, res_s} <= '0;
					not_unit  <= 1'b1;
					saturated <= 1'b0;
				end else begin
					res_x <= m2_o.x;
					res_y <= m2_o.y;
					res_z <= m2_o.z;
					res_s <= '0;
					not_unit  <= 1'b0;
					saturated <= c1_e[D1-1] | m2_clip;
				end
			end
			default: begin
				{res_x, res_y, res_z, res_s} <= '0;
				not_unit  <= 1'b0;
				saturated <= 1'b0;
			end
		endcase
	end

	assign done = done_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion product / rotate unit: a directed
// table of requests, then random requests checked against a local predictor.
// ---------------------------------------------------------------------------
module tb;

	localparam int FRAC     = 29;
	localparam int N_RAND   = 450;
	localparam int WD_LIMIT = 2000;
	localparam int LATENCY  = 7;

	typedef struct {
		logic [qpr_pkg::OP_W-1:0] op;
		qpr_pkg::comp_t a [4];
		qpr_pkg::comp_t b [4];
	} qreq_t;

	typedef struct {
		qpr_pkg::comp_t r [4];
		logic  nu;
		logic  sat;
	} qres_t;

	typedef struct {
		qreq_t req;
		bit    typed;
		qres_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [qpr_pkg::OP_W-1:0] op = '0;
	qpr_pkg::comp_t a_x = '0, a_y = '0, a_z = '0, a_s = '0;
	qpr_pkg::comp_t b_x = '0, b_y = '0, b_z = '0, b_s = '0;
	logic tol_we = 1'b0;
	logic [qpr_pkg::TOL_W-1:0] tol_wdata = '0;
	logic done;
	qpr_pkg::comp_t res_x, res_y, res_z, res_s;
	logic not_unit, saturated;

	always #2 clk = ~clk;

	quaternion_product_rotate_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_s(a_s),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_s(b_s),
		.tol_we(tol_we), .tol_wdata(tol_wdata), .done(done),
		.res_x(res_x), .res_y(res_y), .res_z(res_z), .res_s(res_s),
		.not_unit(not_unit), .saturated(saturated)
	);

	logic [qpr_pkg::TOL_W-1:0] tol_model;
	qres_t pending_q[$];
	int errors = 0, wd = 0, n_req = 0, n_res = 0, n_nu = 0, n_sat = 0;

	function automatic longint rnd_mul(longint x, longint y);
		return (x * y + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint clip32(longint v, ref bit c);
		if (v > 64'sd2147483647) begin
			c = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			c = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// l, r ordered x, y, z, s; cs is the sign on the cross term
	function automatic void hamilton(input longint l[4], input longint r[4],
			input longint cs, output longint o[4], ref bit c);
		longint cr[3];
		cr[0] = rnd_mul(l[1], r[2]) - rnd_mul(l[2], r[1]);
		cr[1] = rnd_mul(l[2], r[0]) - rnd_mul(l[0], r[2]);
		cr[2] = rnd_mul(l[0], r[1]) - rnd_mul(l[1], r[0]);
		for (int i = 0; i < 3; i++)
			o[i] = clip32(rnd_mul(r[3], l[i]) + rnd_mul(l[3], r[i]) + cs * cr[i], c);
		o[3] = clip32(rnd_mul(l[3], r[3]) - rnd_mul(l[0], r[0])
			- rnd_mul(l[1], r[1]) - rnd_mul(l[2], r[2]), c);
	endfunction

	function automatic qres_t predict_quat(qreq_t q);
		qres_t y;
		longint a[4], b[4], v[4], t[4], cj[4], o[4], n2, dev;
		bit c;
		c = 0;
		for (int i = 0; i < 4; i++) begin
			a[i] = q.a[i];
			b[i] = q.b[i];
			o[i] = 0;
		end
		y.nu = 0;
		case (q.op)
			qpr_pkg::OP_CROSS: hamilton(a, b, -1, o, c);
			qpr_pkg::OP_DOT:   hamilton(a, b, 1, o, c);
			qpr_pkg::OP_ROTATE: begin
				n2 = 0;
				for (int i = 0; i < 4; i++)
					n2 += rnd_mul(a[i], a[i]);
				dev = n2 - (64'sd1 <<< FRAC);
				if (dev < 0)
					dev = -dev;
				if (dev > longint'(tol_model)) begin
					y.nu = 1;
				end else begin
					v = '{b[0], b[1], b[2], 0};
					hamilton(a, v, -1, t, c);
					cj = '{-a[0], -a[1], -a[2], a[3]};
					hamilton(t, cj, -1, o, c);
					o[3] = 0;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++)
			y.r[i] = qpr_pkg::comp_t'(o[i]);
		y.sat = c;
		return y;
	endfunction

	function automatic bit same_res(qres_t x, qres_t y);
		bit s;
		s = (x.nu == y.nu) && (x.sat == y.sat);
		for (int i = 0; i < 4; i++)
			if (x.r[i] != y.r[i])
				s = 0;
		return s;
	endfunction

	function automatic qpr_pkg::comp_t rnd_comp();
		case ($urandom_range(0, 5))
			0: return qpr_pkg::comp_t'($urandom);
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			2: return qpr_pkg::comp_t'($urandom_range(0, 2 ** 29)) - 32'sd268435456;
			default: return qpr_pkg::comp_t'($urandom_range(0, 2 ** 30)) - 32'sd536870912;
		endcase
	endfunction

	// near-unit quaternion: one big component plus small noise, or a 90 degree turn
	function automatic qreq_t rnd_rotate();
		qreq_t q;
		int k;
		q.op = qpr_pkg::OP_ROTATE;
		k = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++)
			q.a[i] = qpr_pkg::comp_t'($urandom_range(0, 64)) - 32'sd32;
		q.a[k] = ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) * (32'sd536870912
			+ qpr_pkg::comp_t'($urandom_range(0, 8)) - 32'sd4);
		if ($urandom_range(0, 3) == 0) begin
			// 90 degree turns: 0.7071 in Q2.29
			q.a = '{32'sd0, 32'sd0, 32'sd0, 32'sd379625062};
			q.a[$urandom_range(0, 2)] = 32'sd379625062;
		end
		for (int i = 0; i < 4; i++)
			q.b[i] = rnd_comp();
		return q;
	endfunction

	// start stays high between back-to-back requests
	task automatic send(qreq_t q);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= q.op;
		a_x <= q.a[0]; a_y <= q.a[1]; a_z <= q.a[2]; a_s <= q.a[3];
		b_x <= q.b[0]; b_y <= q.b[1]; b_z <= q.b[2]; b_s <= q.b[3];
		do @(posedge clk); while (busy);
		pending_q.push_back(predict_quat(q));
		n_req++;
	endtask

	task automatic write_tol(logic [qpr_pkg::TOL_W-1:0] t);
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		tol_we <= 1'b1;
		tol_wdata <= t;
		@(posedge clk);
		tol_we <= 1'b0;
		tol_model = t;
	endtask

	task automatic cmp(string nm, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", nm, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		qres_t e;
		if (arst_n && done) begin
			n_res++;
			if (pending_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = pending_q.pop_front();
				cmp("res_x", e.r[0], res_x);
				cmp("res_y", e.r[1], res_y);
				cmp("res_z", e.r[2], res_z);
				cmp("res_s", e.r[3], res_s);
				cmp("not_unit", e.nu, not_unit);
				cmp("saturated", e.sat, saturated);
				n_nu += not_unit;
				n_sat += saturated;
			end
		end
	end

	// watchdog: cycles with no request, result or tolerance write accepted
	always @(posedge clk) begin
		if ((start && !busy) || done || tol_we)
			wd <= 0;
		else
			wd <= wd + 1;
		if (wd >= WD_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	localparam qpr_pkg::comp_t ONE = 32'sd536870912;
	localparam qpr_pkg::comp_t MX  = 32'sh7fffffff;
	localparam qpr_pkg::comp_t MN  = 32'sh80000000;

	function automatic row_t mk(logic [qpr_pkg::OP_W-1:0] o,
			qpr_pkg::comp_t a0, a1, a2, a3,
			qpr_pkg::comp_t b0, b1, b2, b3, bit ty = 0,
			qpr_pkg::comp_t r0 = 0, r1 = 0, r2 = 0,
			qpr_pkg::comp_t r3 = 0, logic nu = 0, logic st = 0);
		row_t w;
		w.req.op = o;
		w.req.a = '{a0, a1, a2, a3};
		w.req.b = '{b0, b1, b2, b3};
		w.typed = ty;
		w.want.r = '{r0, r1, r2, r3};
		w.want.nu = nu;
		w.want.sat = st;
		return w;
	endfunction

	row_t dir_tab[$];
	qres_t got;

	initial begin
		tol_model = 4;
		dir_tab = '{
			mk(qpr_pkg::OP_CROSS, 0, 0, 0, 0, 0, 0, 0, 0, 1),
			mk(qpr_pkg::OP_CROSS, 0, 0, 0, ONE, 0, 0, 0, ONE, 1, 0, 0, 0, ONE),
			mk(qpr_pkg::OP_DOT, 0, 0, 0, ONE, 1, 2, 3, 4, 1, 1, 2, 3, 4),
			mk(qpr_pkg::OP_CROSS, ONE, 0, 0, 0, 0, ONE, 0, 0),
			mk(qpr_pkg::OP_DOT, ONE, 0, 0, 0, 0, ONE, 0, 0),
			mk(qpr_pkg::OP_CROSS, MX, MX, MX, MX, MX, MX, MX, MX),
			mk(qpr_pkg::OP_DOT, MN, MN, MN, MN, MN, MN, MN, MN),
			mk(qpr_pkg::OP_CROSS, MN, MX, MN, MX, MX, MN, MX, MN),
			mk(qpr_pkg::OP_DOT, -1, -1, -1, -1, 1, 1, 1, 1),
			mk(qpr_pkg::OP_NONE, MX, MN, 5, 7, MX, MN, 5, 7, 1),
			mk(qpr_pkg::OP_ROTATE, 0, 0, 0, ONE, 11, -22, 33, MX, 1, 11, -22, 33, 0),
			mk(qpr_pkg::OP_ROTATE, 0, 0, 0, 0, 1, 2, 3, 4, 1, 0, 0, 0, 0, 1),
			mk(qpr_pkg::OP_ROTATE, 0, 0, 0, ONE + 4, 1, 2, 3, 0),
			mk(qpr_pkg::OP_ROTATE, 0, 0, 0, ONE + 5, 1, 2, 3, 0),
			mk(qpr_pkg::OP_ROTATE, 0, 0, ONE, 0, MX, MN, MX, 0),
			mk(qpr_pkg::OP_ROTATE, 0, 0, 0, -ONE, MN, MN, MN, MN),
			mk(qpr_pkg::OP_ROTATE, MX, MX, MX, MX, 1, 1, 1, 1, 1, 0, 0, 0, 0, 1),
			mk(qpr_pkg::OP_ROTATE, 32'sd379625062, 0, 0, 32'sd379625062, 0, MX, MN, 0)
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			if (dir_tab[i].typed) begin
				got = predict_quat(dir_tab[i].req);
				if (!same_res(got, dir_tab[i].want)) begin
					$error("directed row %0d: table and predictor disagree", i);
					errors++;
				end
			end
			send(dir_tab[i].req);
		end
		// tolerance sweep: zero, max, then random values up to 2000
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_tol('0);
				1: write_tol('1);
				default: write_tol(qpr_pkg::TOL_W'($urandom_range(0, 2000)));
			endcase
			for (int i = 0; i < N_RAND / 5; i++) begin
				qreq_t q;
				if ($urandom_range(0, 9) < 4) begin
					q = rnd_rotate();
				end else begin
					q.op = qpr_pkg::OP_W'($urandom_range(0, 3));
					for (int k = 0; k < 4; k++) begin
						q.a[k] = rnd_comp();
						q.b[k] = rnd_comp();
					end
				end
				send(q);
			end
		end
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
		$display("tb: %0d requests, %0d results (%0d not unit, %0d saturated)",
			n_req, n_res, n_nu, n_sat);
		$display("tb: tolerance swept over 0, max and random settings");
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
